FILE: rtl/crps_pkg.sv
// shared constants, codes and controller/datapath interface types for the
// catmull-rom path sampler; no dependencies
`timescale 1ns / 1ps
package crps_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int MAX_SAMPLES_DEF = 64;
    localparam int NCOORD          = 6;   // pos x,y,z then dir x,y,z
    localparam int U_BITS          = 16;  // u in Q0.16
    localparam int W_BITS          = 18;  // rounded weight, signed Q.16
    localparam int N_BITS          = 52;  // exact weight numerator, Q0.48 plus headroom
    localparam int RND_SHIFT       = 16;  // weight fraction bits
    localparam int ADDR_BITS       = 3;

    localparam logic [U_BITS-1:0] USTEP_RESET = 16'd1456;
    localparam logic              REG_USTEP   = 1'b0;   // register index (paddr[2])

    localparam logic CMD_POINT = 1'b0;
    localparam logic CMD_CLOSE = 1'b1;

    typedef struct packed {
        logic              load_in;     // latch new point from input ports
        logic              load_first;  // latch stored first point first_idx
        logic              wr_first;    // store input point at first_idx
        logic [1:0]        first_idx;
        logic              shift;       // shift window, new point enters
        logic              issue;       // start one sample
        logic [U_BITS-1:0] issue_u;
        logic              issue_last;
    } t_dp_cmd;

    typedef struct packed {
        logic en;    // pipeline advances this cycle
        logic busy;  // samples still need the window
    } t_dp_stat;

endpackage

FILE: rtl/crps_ctrl.sv
// sequencer for the sampler: point bookkeeping, close sequence and u stepping
// depends on crps_pkg
`timescale 1ns / 1ps
module crps_ctrl #(
    parameter int MAX_SAMPLES = crps_pkg::MAX_SAMPLES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        i_command,
    input  logic [crps_pkg::U_BITS-1:0] i_u_step,
    input  crps_pkg::t_dp_stat          i_stat,
    output logic                        o_ready,
    output crps_pkg::t_dp_cmd           o_cmd
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int UA_W  = crps_pkg::U_BITS + 1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_SHIFT = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [1:0]       r_pts, n_pts;      // points seen, saturating at three
    logic [1:0]       r_close, n_close;
    logic [UA_W-1:0]  r_u, n_u;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    logic             accept;
    logic [1:0]       pts_eff;
    logic [UA_W-1:0]  u_next;
    logic [CNT_W-1:0] cnt_next;
    logic             more;

    assign o_ready  = (r_state == ST_IDLE);
    assign accept   = i_valid && o_ready;
    assign pts_eff  = (r_close != 2'd0) ? 2'd0 : r_pts;
    assign u_next   = r_u + UA_W'(i_u_step);
    assign cnt_next = r_cnt + CNT_W'(1);
    assign more     = (u_next[UA_W-1] == 1'b0) && (cnt_next < CNT_W'(MAX_SAMPLES));

    always_comb begin
        n_state = r_state;
        n_pts   = r_pts;
        n_close = r_close;
        n_u     = r_u;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.issue_u    = r_u[crps_pkg::U_BITS-1:0];
        o_cmd.issue_last = !more;
        case (r_state)
            ST_IDLE: begin
                n_u   = '0;
                n_cnt = '0;
                if (accept) begin
                    if (i_command == crps_pkg::CMD_POINT) begin
                        o_cmd.load_in   = 1'b1;
                        o_cmd.first_idx = pts_eff;
                        n_close         = 2'd0;
                        n_pts           = (pts_eff == 2'd3) ? 2'd3 : pts_eff + 2'd1;
                        if (pts_eff == 2'd3) begin
                            n_state = ST_RUN;
                        end else begin
                            o_cmd.wr_first = 1'b1;
                            n_state        = ST_SHIFT;
                        end
                    end else if (r_pts == 2'd3) begin
                        o_cmd.load_first = 1'b1;
                        o_cmd.first_idx  = r_close;
                        n_state          = ST_RUN;
                        if (r_close == 2'd2) begin
                            n_close = 2'd0;
                            n_pts   = 2'd0;
                        end else begin
                            n_close = r_close + 2'd1;
                        end
                    end
                end
            end
            ST_RUN: begin
                if (i_stat.en) begin
                    o_cmd.issue = 1'b1;
                    n_u         = u_next;
                    n_cnt       = cnt_next;
                    if (!more) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (!i_stat.busy) begin
                    n_state = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                o_cmd.shift = 1'b1;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pts   <= 2'd0;
            r_close <= 2'd0;
            r_u     <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_pts   <= n_pts;
            r_close <= n_close;
            r_u     <= n_u;
            r_cnt   <= n_cnt;
        end
    end

endmodule

FILE: rtl/crps_dp.sv
// sampler datapath: point window, stored first points, weight pipeline,
// six blend lanes and output register; depends on crps_pkg
`timescale 1ns / 1ps
module crps_dp #(
    parameter int COORD_WIDTH = crps_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  crps_pkg::t_dp_cmd             i_cmd,
    input  logic signed [COORD_WIDTH-1:0] i_coord [crps_pkg::NCOORD],
    output crps_pkg::t_dp_stat            o_stat,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [COORD_WIDTH-1:0] o_coord [crps_pkg::NCOORD],
    output logic                          o_last
);

    localparam int CW = COORD_WIDTH;
    localparam int UB = crps_pkg::U_BITS;
    localparam int WW = crps_pkg::W_BITS;
    localparam int NW = crps_pkg::N_BITS;
    localparam int NC = crps_pkg::NCOORD;
    localparam int PW = CW + WW;
    localparam int SW = PW + 2;
    localparam int RS = crps_pkg::RND_SHIFT;

    localparam logic signed [NW-1:0] N_HALF = NW'(64'sd1 <<< 32);
    localparam logic signed [NW-1:0] N_ONE  = NW'(64'sd1 <<< 49);
    localparam logic signed [SW-1:0] S_HALF = SW'(64'sd1 <<< (RS - 1));
    localparam logic signed [SW-1:0] SAT_HI = (SW'(1) <<< (CW - 1)) - SW'(1);
    localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

    logic signed [CW-1:0] r_win   [3][NC];
    logic signed [CW-1:0] r_first [3][NC];
    logic signed [CW-1:0] r_np    [NC];

    logic              en;
    logic              r1_v, r2_v, r3_v, r4_v, r5_v;
    logic              r1_l, r2_l, r3_l, r4_l, r5_l;
    logic [UB-1:0]     r1_u, r2_u, r3_u;
    logic [2*UB-1:0]   r2_u2, r3_u2;
    logic [3*UB-1:0]   r3_u3;
    logic signed [WW-1:0] r4_w [4];
    logic signed [PW-1:0] r5_p [NC][4];

    logic signed [NW-1:0] u_s, u2_s, u3_s;
    logic signed [NW-1:0] n_num [4];
    logic signed [NW-1:0] n_rnd [4];
    logic signed [SW-1:0] s_sum [NC];
    logic signed [SW-1:0] s_sh  [NC];
    logic signed [CW-1:0] s_sat [NC];

    assign en          = !o_valid || i_ready;
    assign o_stat.en   = en;
    assign o_stat.busy = r1_v || r2_v || r3_v || r4_v;

    // point store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < 3; p++) begin
                for (int a = 0; a < NC; a++) begin
                    r_win[p][a] <= '0;
                end
            end
        end else if (i_cmd.shift) begin
            for (int a = 0; a < NC; a++) begin
                r_win[0][a] <= r_win[1][a];
                r_win[1][a] <= r_win[2][a];
                r_win[2][a] <= r_np[a];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_first) begin
            r_first[i_cmd.first_idx] <= i_coord;
        end
        if (i_cmd.load_in) begin
            r_np <= i_coord;
        end else if (i_cmd.load_first) begin
            r_np <= r_first[i_cmd.first_idx];
        end
    end

    // weight numerators, exact in Q0.48
    always_comb begin
        u_s  = NW'(r3_u);
        u2_s = NW'(r3_u2);
        u3_s = NW'(r3_u3);
        n_num[0] = -(u_s <<< 32) + (u2_s <<< 17) - u3_s;
        n_num[1] = N_ONE - 5 * (u2_s <<< 16) + 3 * u3_s;
        n_num[2] = (u_s <<< 32) + (u2_s <<< 18) - 3 * u3_s;
        n_num[3] = -(u2_s <<< 16) + u3_s;
        for (int i = 0; i < 4; i++) begin
            n_rnd[i] = n_num[i] + N_HALF;
        end
    end

    // blend: round half up, saturate
    always_comb begin
        for (int a = 0; a < NC; a++) begin
            s_sum[a] = SW'(r5_p[a][0]) + SW'(r5_p[a][1]) + SW'(r5_p[a][2])
                     + SW'(r5_p[a][3]) + S_HALF;
            s_sh[a]  = s_sum[a] >>> RS;
            if (s_sh[a] > SAT_HI) begin
                s_sat[a] = SAT_HI[CW-1:0];
            end else if (s_sh[a] < SAT_LO) begin
                s_sat[a] = SAT_LO[CW-1:0];
            end else begin
                s_sat[a] = s_sh[a][CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            r4_v    <= 1'b0;
            r5_v    <= 1'b0;
            o_valid <= 1'b0;
        end else if (en) begin
            r1_v    <= i_cmd.issue;
            r2_v    <= r1_v;
            r3_v    <= r2_v;
            r4_v    <= r3_v;
            r5_v    <= r4_v;
            o_valid <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_u  <= i_cmd.issue_u;
            r1_l  <= i_cmd.issue_last;
            r2_u  <= r1_u;
            r2_u2 <= r1_u * r1_u;
            r2_l  <= r1_l;
            r3_u  <= r2_u;
            r3_u2 <= r2_u2;
            r3_u3 <= r2_u2 * r2_u;
            r3_l  <= r2_l;
            for (int i = 0; i < 4; i++) begin
                r4_w[i] <= n_rnd[i][WW+32:33];
            end
            r4_l <= r3_l;
            for (int a = 0; a < NC; a++) begin
                for (int i = 0; i < 3; i++) begin
                    r5_p[a][i] <= PW'(r4_w[i]) * PW'(r_win[i][a]);
                end
                r5_p[a][3] <= PW'(r4_w[3]) * PW'(r_np[a]);
            end
            r5_l    <= r4_l;
            o_coord <= s_sat;
            o_last  <= r5_l;
        end
    end

endmodule

FILE: rtl/catmull_rom_path_sampler_unit.sv
// top level of the uniform catmull-rom path sampler: config register,
// sequencer and datapath; depends on crps_pkg, crps_ctrl, crps_dp
`timescale 1ns / 1ps
// Feeds a closed loop of control points (position and direction, signed
// Q15.16) and returns uniform Catmull-Rom samples, one word per sample, the
// last of each segment flagged by o_segment_last. The first three points of
// a loop are stored and return nothing; each later point returns one
// segment sampled at u = 0, u_step, ... while u < 1 (at most MAX_SAMPLES);
// three close commands then return the wrap-around segments and end the
// loop. A close with fewer than three points is dropped. The sample count
// per segment is N = min(ceil(65536 / u_step), MAX_SAMPLES). An emitting
// item issues one sample per cycle (while the result side does not stall)
// into the six-stage weight and blend pipeline, then a drain and a window
// shift; a stored point only shifts the window. Back-pressure on the result
// side stalls the whole pipeline and lengthens the item by the stall.
// u_step lies at byte address 0 of the register port, reset 1456.
module catmull_rom_path_sampler_unit #(
    parameter int COORD_WIDTH = crps_pkg::COORD_WIDTH_DEF,
    parameter int MAX_SAMPLES = crps_pkg::MAX_SAMPLES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // register port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [crps_pkg::ADDR_BITS-1:0]     paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    // control point words
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_command,
    input  logic signed [COORD_WIDTH-1:0]      i_pos_x,
    input  logic signed [COORD_WIDTH-1:0]      i_pos_y,
    input  logic signed [COORD_WIDTH-1:0]      i_pos_z,
    input  logic signed [COORD_WIDTH-1:0]      i_dir_x,
    input  logic signed [COORD_WIDTH-1:0]      i_dir_y,
    input  logic signed [COORD_WIDTH-1:0]      i_dir_z,
    // sample words
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [COORD_WIDTH-1:0]      o_out_pos_x,
    output logic signed [COORD_WIDTH-1:0]      o_out_pos_y,
    output logic signed [COORD_WIDTH-1:0]      o_out_pos_z,
    output logic signed [COORD_WIDTH-1:0]      o_out_dir_x,
    output logic signed [COORD_WIDTH-1:0]      o_out_dir_y,
    output logic signed [COORD_WIDTH-1:0]      o_out_dir_z,
    output logic                               o_segment_last
);

    logic [crps_pkg::U_BITS-1:0]   r_u_step;
    crps_pkg::t_dp_cmd             dp_cmd;
    crps_pkg::t_dp_stat            dp_stat;
    logic signed [COORD_WIDTH-1:0] in_coord  [crps_pkg::NCOORD];
    logic signed [COORD_WIDTH-1:0] out_coord [crps_pkg::NCOORD];

    // register port, no wait states
    assign pready = 1'b1;
    assign prdata = (paddr[2] == crps_pkg::REG_USTEP) ? 32'(r_u_step) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u_step <= crps_pkg::USTEP_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == crps_pkg::REG_USTEP) begin
            r_u_step <= pwdata[crps_pkg::U_BITS-1:0];
        end
    end

    // coordinates travel as one lane vector, position first
    assign in_coord[0] = i_pos_x;
    assign in_coord[1] = i_pos_y;
    assign in_coord[2] = i_pos_z;
    assign in_coord[3] = i_dir_x;
    assign in_coord[4] = i_dir_y;
    assign in_coord[5] = i_dir_z;

    assign o_out_pos_x = out_coord[0];
    assign o_out_pos_y = out_coord[1];
    assign o_out_pos_z = out_coord[2];
    assign o_out_dir_x = out_coord[3];
    assign o_out_dir_y = out_coord[4];
    assign o_out_dir_z = out_coord[5];

    // sequencer: loop bookkeeping and u stepping
    crps_ctrl #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .i_u_step  (r_u_step),
        .i_stat    (dp_stat),
        .o_ready   (o_ready),
        .o_cmd     (dp_cmd)
    );

    // datapath: window, weights, blend lanes, output register
    crps_dp #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (dp_cmd),
        .i_coord (in_coord),
        .o_stat  (dp_stat),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_coord (out_coord),
        .o_last  (o_segment_last)
    );

endmodule

FILE: rtl/crps_chk.sv
// port-level checks for the sampler top level, attached by bind
// depends on catmull_rom_path_sampler_unit
`timescale 1ns / 1ps
module crps_chk #(
    parameter int COORD_WIDTH = 32
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_valid,
    input logic                   o_ready,
    input logic                   i_command,
    input logic                   o_valid,
    input logic                   i_ready,
    input logic [COORD_WIDTH-1:0] o_out_pos_x,
    input logic                   o_segment_last
);

    // a stalled sample word stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("sample word withdrawn while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_out_pos_x) && $stable(o_segment_last))
        else $error("sample word changed while stalled");

    // reset leaves the block empty and ready for a word
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("block not empty after reset");

    // an accepted control point always leaves the block busy in the cycle after
    a_point_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && !i_command |=> !o_ready)
        else $error("control point accepted without window update");

endmodule

bind catmull_rom_path_sampler_unit crps_chk #(
    .COORD_WIDTH (COORD_WIDTH)
) u_crps_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .i_command      (i_command),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_out_pos_x    (o_out_pos_x),
    .o_segment_last (o_segment_last)
);

FILE: tb/sv/crps_sample_checker.sv
// sample checker for the catmull-rom path sampler: watches the register port and
// both word channels, predicts every sample word and compares; depends on crps_pkg
`timescale 1ns / 1ps
module crps_sample_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               i_valid,
    input  logic               o_ready,
    input  logic               i_command,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [31:0] i_dir_x,
    input  logic signed [31:0] i_dir_y,
    input  logic signed [31:0] i_dir_z,
    input  logic               o_valid,
    input  logic               i_ready,
    input  logic signed [31:0] o_out_pos_x,
    input  logic signed [31:0] o_out_pos_y,
    input  logic signed [31:0] o_out_pos_z,
    input  logic signed [31:0] o_out_dir_x,
    input  logic signed [31:0] o_out_dir_y,
    input  logic signed [31:0] o_out_dir_z,
    input  logic               o_segment_last,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic [5:0][31:0] coord;
        logic             last;
    } t_sample;

    t_sample          samples_due[$];
    logic [15:0]      step_reg;
    longint           win[6][3];   // [pos x,y,z dir x,y,z][oldest..newest]
    longint           first_pt[3][6];
    int               n_points;
    int               n_closes;

    assign o_pending = samples_due.size();

    function automatic longint round_weight(input longint num);
        longint one;
        one = 1;
        return (num + (one <<< 32)) >>> 33;
    endfunction

    function automatic logic [31:0] blend_axis(input longint w[4], input longint c[4]);
        longint acc;
        acc = 0;
        for (int i = 0; i < 4; i++) acc += w[i] * c[i];
        acc = (acc + 32768) >>> 16;
        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
        if (acc < -64'sd2147483648) acc = -64'sd2147483648;
        return acc[31:0];
    endfunction

    // queue the samples of one segment, window plus new point
    task automatic predict_segment(input longint pt[6]);
        longint  u, u2, u3, one, w[4], c[4];
        int      count;
        logic    more;
        t_sample s;
        one   = 1;
        u     = 0;
        count = 0;
        more  = 1'b1;
        while (more) begin
            u2   = u * u;
            u3   = u2 * u;
            w[0] = round_weight(-u * (one <<< 32) + 2 * u2 * 65536 - u3);
            w[1] = round_weight((one <<< 49) - 5 * u2 * 65536 + 3 * u3);
            w[2] = round_weight(u * (one <<< 32) + 4 * u2 * 65536 - 3 * u3);
            w[3] = round_weight(-u2 * 65536 + u3);
            for (int k = 0; k < 6; k++) begin
                for (int i = 0; i < 3; i++) c[i] = win[k][i];
                c[3] = pt[k];
                s.coord[k] = blend_axis(w, c);
            end
            u     = (u + step_reg) & 17'h1FFFF;
            count++;
            more  = (u < 65536) && (count < crps_pkg::MAX_SAMPLES_DEF);
            s.last = !more;
            samples_due.insert(samples_due.size(), s);
        end
    endtask

    task automatic shift_in(input longint pt[6]);
        for (int k = 0; k < 6; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
            win[k][2] = pt[k];
        end
    endtask

    task automatic take_word();
        longint pt[6];
        if (i_command == crps_pkg::CMD_POINT) begin
            if (n_closes != 0) begin
                n_closes = 0;
                n_points = 0;
            end
            pt = '{i_pos_x, i_pos_y, i_pos_z, i_dir_x, i_dir_y, i_dir_z};
            if (n_points < 3) first_pt[n_points] = pt;
            else predict_segment(pt);
            shift_in(pt);
            if (n_points < 65535) n_points++;
        end else if (n_points >= 3) begin
            pt = first_pt[n_closes % 3];
            predict_segment(pt);
            shift_in(pt);
            n_closes++;
            if (n_closes >= 3) begin
                n_closes = 0;
                n_points = 0;
            end
        end
    endtask

    task automatic check_word();
        t_sample got, want;
        got.coord = {o_out_dir_z, o_out_dir_y, o_out_dir_x,
                     o_out_pos_z, o_out_pos_y, o_out_pos_x};
        got.last  = o_segment_last;
        if (samples_due.size() == 0) begin
            o_fail_count++;
            if (o_fail_count <= 10) $display("unexpected sample word %h", got);
            return;
        end
        want = samples_due.pop_front();
        if (got !== want) begin
            o_fail_count++;
            if (o_fail_count <= 10) begin
                $display("sample mismatch");
                for (int k = 0; k < 6; k++)
                    $display("  coord %0d exp %h got %h", k, want.coord[k], got.coord[k]);
                $display("  last exp %b got %b", want.last, got.last);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            step_reg     = crps_pkg::USTEP_RESET;
            n_points     = 0;
            n_closes     = 0;
            o_fail_count = 0;
            samples_due.delete();
            for (int k = 0; k < 6; k++) win[k] = '{0, 0, 0};
        end else begin
            if (o_valid && i_ready) check_word();
            if (psel && penable && pwrite && pready && paddr[2] == crps_pkg::REG_USTEP)
                step_reg = pwdata[15:0];
            if (i_valid && o_ready) take_word();
        end
    end

endmodule

FILE: tb/sv/tb_catmull_rom_path_sampler_unit.sv
// testbench top for catmull_rom_path_sampler_unit: clock, reset, register writes,
// control point stimulus and verdict; depends on crps_pkg and crps_sample_checker
`timescale 1ns / 1ps
module tb_catmull_rom_path_sampler_unit;

    localparam int ITEM_TARGET = 270;
    localparam int STALL_LIMIT = 20000;  // cycles with no word moving
    localparam int DRAIN_WAIT  = 80;     // pipeline drain plus window shift

    logic               i_clk, i_rst_n;
    logic               psel, penable, pwrite, pready;
    logic [2:0]         paddr;
    logic [31:0]        pwdata, prdata;
    logic               i_valid, o_ready, i_command;
    logic signed [31:0] i_pos_x, i_pos_y, i_pos_z, i_dir_x, i_dir_y, i_dir_z;
    logic               o_valid, i_ready, o_segment_last;
    logic signed [31:0] o_out_pos_x, o_out_pos_y, o_out_pos_z;
    logic signed [31:0] o_out_dir_x, o_out_dir_y, o_out_dir_z;
    int                 fail_count, pending;

    int                 gap_pct, stall_pct;  // percent of cycles idle on each side
    int                 words_sent;
    int                 quiet_cycles;

    catmull_rom_path_sampler_unit i_dut (.*);

    crps_sample_checker i_chk (
        .*,
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result side back-pressure
    always @(negedge i_clk)
        i_ready <= (stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= stall_pct);

    // watchdog: nothing moving on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("catmull_rom_path_sampler_unit verification failed");
            $finish;
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic reg_write(input logic [15:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 3'd0;
        pwdata  <= {16'h0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // send one word, then maybe leave the input idle for a while
    task automatic send_word(input logic cmd, input logic signed [31:0] p[6]);
        i_valid   <= 1'b1;
        i_command <= cmd;
        {i_pos_x, i_pos_y, i_pos_z} <= {p[0], p[1], p[2]};
        {i_dir_x, i_dir_y, i_dir_z} <= {p[3], p[4], p[5]};
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        words_sent++;
        if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            while ($urandom_range(99) < gap_pct) @(negedge i_clk);
            @(negedge i_clk);
        end
    endtask

    function automatic logic signed [31:0] pick_coord();
        case ($urandom_range(9))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return 32'sh0;
            3: return $signed($urandom_range(2097151)) - 32'sd1048576;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_point();
        logic signed [31:0] p[6];
        foreach (p[k]) p[k] = pick_coord();
        send_word(crps_pkg::CMD_POINT, p);
    endtask

    task automatic send_flat(input logic cmd, input logic signed [31:0] v);
        logic signed [31:0] p[6];
        foreach (p[k]) p[k] = v;
        send_word(cmd, p);
    endtask

    // one closed loop, sometimes with a stray close up front or an abandoned close
    task automatic send_loop();
        int n_pts, n_cls;
        if ($urandom_range(9) == 0) send_flat(crps_pkg::CMD_CLOSE, $urandom);
        n_pts = $urandom_range(3, 7);
        n_cls = ($urandom_range(6) == 0) ? $urandom_range(1, 2) : 3;
        repeat (n_pts) send_point();
        repeat (n_cls) send_flat(crps_pkg::CMD_CLOSE, $urandom);
    endtask

    // quiet the block before a register write
    task automatic settle();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    initial begin
        logic [15:0] steps[$];
        logic signed [31:0] mix[6];
        int phase;
        i_rst_n   = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        i_valid   = 1'b0;
        i_command = crps_pkg::CMD_POINT;
        {i_pos_x, i_pos_y, i_pos_z, i_dir_x, i_dir_y, i_dir_z} = '0;
        gap_pct   = 0;
        stall_pct = 0;
        words_sent = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: reset step size, extremes, early close, abandoned close
        send_flat(crps_pkg::CMD_CLOSE, 32'sh7FFFFFFF);     // too early, dropped
        send_flat(crps_pkg::CMD_POINT, 32'sh7FFFFFFF);
        send_flat(crps_pkg::CMD_POINT, 32'sh80000000);
        send_flat(crps_pkg::CMD_CLOSE, 32'sh0);            // still too early
        send_flat(crps_pkg::CMD_POINT, 32'sh0);
        send_flat(crps_pkg::CMD_POINT, 32'sh7FFFFFFF);     // swings drive saturation
        send_flat(crps_pkg::CMD_POINT, 32'sh80000000);
        send_flat(crps_pkg::CMD_POINT, 32'sh7FFFFFFF);
        mix = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh1, -32'sh1, 32'sh10000, -32'sh10000};
        send_word(crps_pkg::CMD_POINT, mix);
        repeat (3) send_flat(crps_pkg::CMD_CLOSE, 32'sh0);
        repeat (3) send_point();
        send_flat(crps_pkg::CMD_CLOSE, 32'sh0);
        send_point();                            // point mid-close starts a new loop
        repeat (3) send_point();
        repeat (2) send_flat(crps_pkg::CMD_CLOSE, 32'sh0);
        send_flat(crps_pkg::CMD_POINT, 32'sh12345678);     // abandoned after two closes
        repeat (3) send_point();
        repeat (3) send_flat(crps_pkg::CMD_CLOSE, 32'sh0);

        // step sizes: extremes, below range (capped count), typical
        steps = '{16'd65535, 16'd1024, 16'd0, 16'd100, 16'd16384, 16'd65535,
                  16'd1456, 16'd5000};
        phase = 0;
        while (words_sent < ITEM_TARGET - 20) begin
            settle();
            if (phase < steps.size()) reg_write(steps[phase]);
            else reg_write($urandom_range(65535, 1024));
            case (phase % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 53; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 53; end
                default: begin gap_pct = 26; stall_pct = 26; end
            endcase
            repeat ($urandom_range(2, 4)) send_loop();
            phase++;
        end

        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("catmull_rom_path_sampler_unit verification clean");
        else
            $display("catmull_rom_path_sampler_unit verification failed");
        $finish;
    end

endmodule
